FILE: rtl/kwsc_pkg.sv
// Shared types and constants for the keyed word stream cipher.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps

package kwsc_pkg;

    localparam int KEY_WORDS = 16;
    localparam int WORD_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW      = 3'd0,
        REG_KEY_MID_LOW  = 3'd1,
        REG_KEY_MID_HIGH = 3'd2,
        REG_KEY_HIGH     = 3'd3,
        REG_VERSION      = 3'd4,
        REG_DIRECTION    = 3'd5
    } cfg_reg_t;

    // Format versions that alter the chaining words
    localparam logic [7:0] VER_FIX_LO = 8'h15;
    localparam logic [7:0] VER_FIX_HI = 8'h17;
    localparam logic [7:0] VER_ALT    = 8'h1D;

    localparam logic [WORD_W-1:0] CHAIN_A_FIX = 16'h1234;
    localparam logic [WORD_W-1:0] CHAIN_B_FIX = 16'h5678;
    localparam logic [WORD_W-1:0] CHAIN_B_ALT = 16'h57AE;
    localparam logic [WORD_W-1:0] SLOT2_MASK  = 16'h55AA;

    localparam logic DIR_DECRYPT = 1'b0;
    localparam logic DIR_ENCRYPT = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_bank_t;

    typedef struct packed {
        key_bank_t  keys;
        logic [7:0] version;
        logic       direction;
    } kwsc_cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              first_word;
    } kwsc_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        kwsc_item_t item;
    } kwsc_head_t;

endpackage

FILE: rtl/kwsc_cfg.sv
// Configuration register file: key words, format version, direction.
// Depends on kwsc_pkg.
`timescale 1ns / 1ps

module kwsc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kwsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kwsc_pkg::CFG_DAT_W-1:0]  cfg_data,
    output kwsc_pkg::kwsc_cfg_t             cfg
);
    import kwsc_pkg::*;

    kwsc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_LOW:      cfg_reg.keys[3:0]   <= cfg_data;
                REG_KEY_MID_LOW:  cfg_reg.keys[7:4]   <= cfg_data;
                REG_KEY_MID_HIGH: cfg_reg.keys[11:8]  <= cfg_data;
                REG_KEY_HIGH:     cfg_reg.keys[15:12] <= cfg_data;
                REG_VERSION:      cfg_reg.version     <= cfg_data[7:0];
                REG_DIRECTION:    cfg_reg.direction   <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/kwsc_front.sv
// Front end: accepts input beats and holds them in a two-entry queue.
// Depends on kwsc_pkg.
`timescale 1ns / 1ps

module kwsc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [kwsc_pkg::WORD_W-1:0]  s_data_word,
    input  logic                         s_first_word,
    output kwsc_pkg::kwsc_head_t         head,
    input  logic                         pop
);
    import kwsc_pkg::*;

    kwsc_item_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, do_pop;

    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= '{data_word: s_data_word, first_word: s_first_word};
        end
    end

endmodule

FILE: rtl/kwsc_back.sv
// Back end: cipher state, per-position mixing and key updates, output register.
// Depends on kwsc_pkg.
`timescale 1ns / 1ps

module kwsc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  kwsc_pkg::kwsc_cfg_t          cfg,
    input  kwsc_pkg::kwsc_head_t         head,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [kwsc_pkg::WORD_W-1:0]  m_result_word
);
    import kwsc_pkg::*;

    key_bank_t          key_reg, key_next, k_eff;
    logic [WORD_W-1:0]  idx_reg, idx_next, idx_eff, idx_mix;
    logic [WORD_W-1:0]  ca_reg, ca_next, ca_eff, ca_cfg;
    logic [WORD_W-1:0]  cb_reg, cb_next, cb_eff, cb_cfg;
    logic [WORD_W-1:0]  s1_reg, s1_next, s1_eff;
    logic [WORD_W-1:0]  s2_reg, s2_next, s2_eff;
    logic [4:0]         pos_reg, pos_eff;
    logic [2:0]         slot;
    logic [1:0]         grp;
    logic [WORD_W-1:0]  w, kv, c, res;
    logic [WORD_W:0]    half_sum;
    logic               enc, fire;
    logic               m_valid_reg;
    logic [WORD_W-1:0]  m_result_word_reg;

    assign pop           = !m_valid_reg || m_ready;
    assign fire          = pop && head.valid;
    assign m_valid       = m_valid_reg;
    assign m_result_word = m_result_word_reg;

    // Chaining words on reload
    always_comb begin
        ca_cfg = cfg.keys[3] ^ cfg.keys[14];
        cb_cfg = cfg.keys[7] ^ cfg.keys[15];
        if (cfg.version >= VER_FIX_LO && cfg.version <= VER_FIX_HI) begin
            ca_cfg = ca_cfg ^ CHAIN_A_FIX;
            cb_cfg = cb_cfg ^ CHAIN_B_FIX;
        end
        if (cfg.version == VER_ALT) begin
            ca_cfg = cfg.keys[4] ^ cfg.keys[15] ^ CHAIN_A_FIX;
            cb_cfg = cfg.keys[8] ^ cfg.keys[10] ^ CHAIN_B_ALT;
        end
    end

    always_comb begin
        if (head.item.first_word) begin
            k_eff   = cfg.keys;
            idx_eff = '0;
            ca_eff  = ca_cfg;
            cb_eff  = cb_cfg;
            s1_eff  = '0;
            s2_eff  = '0;
            pos_eff = '0;
        end else begin
            k_eff   = key_reg;
            idx_eff = idx_reg;
            ca_eff  = ca_reg;
            cb_eff  = cb_reg;
            s1_eff  = s1_reg;
            s2_eff  = s2_reg;
            pos_eff = pos_reg;
        end
    end

    assign slot     = pos_eff[2:0];
    assign grp      = pos_eff[4:3];
    assign w        = head.item.data_word;
    assign enc      = (cfg.direction == DIR_ENCRYPT);
    // halving step keeps the carry out of the add
    assign half_sum = {1'b0, idx_eff} + {1'b0, ca_eff};

    always_comb begin
        case (slot) inside
            3'd0, 3'd7: idx_mix = idx_eff + ca_eff;
            3'd1:       idx_mix = idx_eff + s1_eff;
            3'd2, 3'd6: idx_mix = idx_eff ^ s2_eff;
            3'd3:       idx_mix = half_sum[WORD_W:1];
            3'd4:       idx_mix = idx_eff + cb_eff;
            default:    idx_mix = idx_eff ^ s1_eff;
        endcase
    end

    assign kv = k_eff[idx_mix[3:0]];

    always_comb begin
        key_next = k_eff;
        idx_next = idx_mix;
        ca_next  = ca_eff;
        cb_next  = cb_eff;
        s1_next  = s1_eff;
        s2_next  = s2_eff;
        case (slot)
            3'd0: begin
                c           = enc ? w - kv : w;
                res         = enc ? c : w + kv;
                s1_next     = c;
                key_next[0] = k_eff[0] ^ c;
            end
            3'd1: begin
                c       = enc ? (w ^ kv) - cb_eff : w;
                res     = enc ? c : (w + cb_eff) ^ kv;
                s2_next = c;
                key_next[cb_eff[3:0]] = k_eff[cb_eff[3:0]] ^ ca_eff;
            end
            3'd2: begin
                c       = enc ? w - kv : w;
                res     = enc ? c : w + kv;
                ca_next = c;
                key_next[cb_eff[3:0]] = k_eff[cb_eff[3:0]] ^ SLOT2_MASK;
            end
            3'd3: begin
                c       = enc ? (w ^ kv) + s1_eff : w;
                res     = enc ? c : (w - s1_eff) ^ kv;
                cb_next = c;
            end
            3'd4: begin
                c       = enc ? w ^ kv : w;
                res     = w ^ kv;
                s1_next = c;
                key_next[ca_eff[3:0]] = k_eff[ca_eff[3:0]] + cb_eff;
            end
            3'd5: begin
                res     = w ^ cb_eff ^ kv;
                c       = enc ? res : w;
                s2_next = c;
                key_next[c[3:0]] = k_eff[c[3:0]] ^ s1_eff;
            end
            3'd6: begin
                c       = enc ? w - kv : w;
                res     = enc ? c : w + kv;
                ca_next = c;
                key_next[s1_eff[3:0]] = k_eff[s1_eff[3:0]] + s2_eff;
            end
            default: begin
                // last word of a group: bulk key update, index steps by group
                c           = enc ? (w ^ kv) - s1_eff : w;
                res         = enc ? c : (w + s1_eff) ^ kv;
                cb_next     = c;
                key_next[2] = k_eff[2] ^ s1_eff;
                key_next[4] = k_eff[4] + s2_eff;
                key_next[6] = k_eff[6] + c;
                key_next[8] = k_eff[8] - ca_eff;
                key_next[1] = k_eff[1] ^ k_eff[15];
                key_next[3] = k_eff[3] ^ k_eff[14];
                key_next[5] = k_eff[5] ^ k_eff[13];
                idx_next    = idx_mix + {{(WORD_W-2){1'b0}}, grp};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            idx_reg     <= '0;
            ca_reg      <= '0;
            cb_reg      <= '0;
            s1_reg      <= '0;
            s2_reg      <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                key_reg <= key_next;
                idx_reg <= idx_next;
                ca_reg  <= ca_next;
                cb_reg  <= cb_next;
                s1_reg  <= s1_next;
                s2_reg  <= s2_next;
                pos_reg <= pos_eff + 5'd1;
            end
            if (pop) begin
                m_valid_reg <= head.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_result_word_reg <= res;
        end
    end

endmodule

FILE: rtl/keyed_word_stream_cipher.sv
// Keyed word stream cipher top level: config registers, input queue, cipher back end.
// An accepted word is registered in the input queue, then in the output register.
// Throughput: one word per cycle unless m_ready stalls; mixing is combinational.
// The two-entry input queue accepts until full while a result waits on m_ready.
// Reset (aresetn low, synchronous) clears config, cipher state, the input queue
// pointers and count, and m_valid; the result word register is not reset.
`timescale 1ns / 1ps

module keyed_word_stream_cipher (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kwsc_pkg::WORD_W-1:0]     s_data_word,
    input  logic                            s_first_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [kwsc_pkg::WORD_W-1:0]     m_result_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kwsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kwsc_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import kwsc_pkg::*;

    kwsc_cfg_t  cfg;
    kwsc_head_t head;
    logic       pop;

    kwsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kwsc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_first_word (s_first_word),
        .head         (head),
        .pop          (pop)
    );

    kwsc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word)
    );

endmodule

FILE: rtl/kwsc_checker.sv
// Port-level checker for keyed_word_stream_cipher, bound to the top level.
// Depends on kwsc_pkg.
`timescale 1ns / 1ps

module kwsc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [kwsc_pkg::WORD_W-1:0] m_result_word
);
    import kwsc_pkg::*;

    // beats inside the block: queue depth plus the output register
    logic [2:0] inflight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 3'd0;
        end else begin
            inflight_reg <= inflight_reg + {2'd0, s_valid && s_ready}
                                         - {2'd0, m_valid && m_ready};
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_word))
        else $error("result beat changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 3'd0)
        else $error("result beat without an accepted input beat");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd3)
        else $error("more beats held than the block can store");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind keyed_word_stream_cipher kwsc_checker u_kwsc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_word (m_result_word)
);

FILE: sim/tb.sv
// Testbench for keyed_word_stream_cipher: directed word table, then random keyed streams.
// Every beat is checked against an in-bench cipher model or, for typed rows, the
// typed result. Depends on rtl/kwsc_pkg.sv and rtl/keyed_word_stream_cipher.sv.
`timescale 1ns / 1ps

module tb;
    import kwsc_pkg::*;

    localparam int N_DIRECTED      = 24;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Indexes past the last register; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic              first;
        logic              known;
        logic [WORD_W-1:0] result;
    } word_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_data_word;
    logic                 s_first_word;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_W-1:0]    m_result_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Typed expectation riding along with the current input beat
    logic                 word_known;
    logic [WORD_W-1:0]    word_typed;
    logic                 idle_on;

    // Cipher model: configuration copy and running state
    logic [CFG_DAT_W-1:0] init_keys [4];
    logic [7:0]           fmt_version;
    logic                 cipher_dir;
    logic [WORD_W-1:0]    key_bank [KEY_WORDS];
    logic [WORD_W-1:0]    mix_index;
    logic [WORD_W-1:0]    link_a;
    logic [WORD_W-1:0]    link_b;
    logic [WORD_W-1:0]    hold_one;
    logic [WORD_W-1:0]    hold_two;
    logic [4:0]           block_pos;

    logic [WORD_W-1:0]    pending_words [$];
    int                   fail_count = 0;
    int                   stall_count = 0;

    keyed_word_stream_cipher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_first_word  (s_first_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_word (m_result_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Returns the output word for one input word and advances the model state
    function automatic logic [WORD_W-1:0] cipher_word(input logic [WORD_W-1:0] w,
                                                      input logic first);
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] k;
        logic [WORD_W:0]   sum17;
        logic              enc;
        logic [1:0]        grp;
        if (first) begin
            for (int i = 0; i < KEY_WORDS; i++)
                key_bank[i] = init_keys[i / 4][16 * (i % 4) +: 16];
            link_a = key_bank[3] ^ key_bank[14];
            link_b = key_bank[7] ^ key_bank[15];
            if (fmt_version >= VER_FIX_LO && fmt_version <= VER_FIX_HI) begin
                link_a ^= CHAIN_A_FIX;
                link_b ^= CHAIN_B_FIX;
            end
            if (fmt_version == VER_ALT) begin
                link_a = key_bank[4] ^ key_bank[15] ^ CHAIN_A_FIX;
                link_b = key_bank[8] ^ key_bank[10] ^ CHAIN_B_ALT;
            end
            mix_index = '0;
            hold_one  = '0;
            hold_two  = '0;
            block_pos = '0;
        end
        enc = (cipher_dir == DIR_ENCRYPT);
        grp = block_pos[4:3];
        // state always follows the enciphered word, whatever the direction
        case (block_pos[2:0])
            3'd0: begin
                mix_index = mix_index + link_a;
                k = key_bank[mix_index[3:0]];
                c = enc ? w - k : w;
                res = enc ? c : w + k;
                hold_one = c;
                key_bank[0] ^= c;
            end
            3'd1: begin
                mix_index = mix_index + hold_one;
                k = key_bank[mix_index[3:0]];
                c = enc ? (w ^ k) - link_b : w;
                res = enc ? c : (w + link_b) ^ k;
                hold_two = c;
                key_bank[link_b[3:0]] ^= link_a;
            end
            3'd2: begin
                mix_index = mix_index ^ hold_two;
                k = key_bank[mix_index[3:0]];
                c = enc ? w - k : w;
                res = enc ? c : w + k;
                link_a = c;
                key_bank[link_b[3:0]] ^= SLOT2_MASK;
            end
            3'd3: begin
                // carry out of the sum lands in bit 15
                sum17 = {1'b0, mix_index} + {1'b0, link_a};
                mix_index = sum17[WORD_W:1];
                k = key_bank[mix_index[3:0]];
                c = enc ? (w ^ k) + hold_one : w;
                res = enc ? c : (w - hold_one) ^ k;
                link_b = c;
            end
            3'd4: begin
                mix_index = mix_index + link_b;
                k = key_bank[mix_index[3:0]];
                c = enc ? w ^ k : w;
                res = w ^ k;
                hold_one = c;
                key_bank[link_a[3:0]] = key_bank[link_a[3:0]] + link_b;
            end
            3'd5: begin
                mix_index = mix_index ^ hold_one;
                k = key_bank[mix_index[3:0]];
                res = w ^ link_b ^ k;
                c = enc ? res : w;
                hold_two = c;
                key_bank[c[3:0]] ^= hold_one;
            end
            3'd6: begin
                mix_index = mix_index ^ hold_two;
                k = key_bank[mix_index[3:0]];
                c = enc ? w - k : w;
                res = enc ? c : w + k;
                link_a = c;
                key_bank[hold_one[3:0]] = key_bank[hold_one[3:0]] + hold_two;
            end
            default: begin
                mix_index = mix_index + link_a;
                k = key_bank[mix_index[3:0]];
                c = enc ? (w ^ k) - hold_one : w;
                res = enc ? c : (w + hold_one) ^ k;
                link_b = c;
                // end-of-group bulk key update
                key_bank[2] ^= hold_one;
                key_bank[4] = key_bank[4] + hold_two;
                key_bank[6] = key_bank[6] + link_b;
                key_bank[8] = key_bank[8] - link_a;
                key_bank[1] ^= key_bank[15];
                key_bank[3] ^= key_bank[14];
                key_bank[5] ^= key_bank[13];
                mix_index = mix_index + {14'd0, grp};
            end
        endcase
        block_pos = block_pos + 5'd1;
        return res;
    endfunction

    // Monitor: model update on accepted beats, result compare, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index) inside
                    REG_KEY_LOW, REG_KEY_MID_LOW, REG_KEY_MID_HIGH, REG_KEY_HIGH:
                        init_keys[cfg_index[1:0]] = cfg_data;
                    REG_VERSION:   fmt_version = cfg_data[7:0];
                    REG_DIRECTION: cipher_dir = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (word_known) begin
                    void'(cipher_word(s_data_word, s_first_word));
                    pending_words.push_back(word_typed);
                end else begin
                    pending_words.push_back(cipher_word(s_data_word, s_first_word));
                end
            end
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $error("result_word beat with nothing expected: got %h", m_result_word);
                    fail_count++;
                end else if (m_result_word !== pending_words[0]) begin
                    $error("result_word mismatch: expected %h, actual %h",
                           pending_words[0], m_result_word);
                    fail_count++;
                    void'(pending_words.pop_front());
                end else begin
                    void'(pending_words.pop_front());
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("[keyed_word_stream_cipher] ERROR");
                $finish;
            end
        end
    end

    // Result side backpressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic push_word(input logic [WORD_W-1:0] w, input logic first,
                             input logic known, input logic [WORD_W-1:0] typed);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_data_word  = w;
        s_first_word = first;
        word_known   = known;
        word_typed   = typed;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every expected word is back, then let the pipeline settle
    task automatic drain_words();
        s_valid = 1'b0;
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        word_row_t            directed_rows [N_DIRECTED];
        cfg_reg_t             key_regs [4];
        logic [7:0]           version_plan [N_PHASES];
        logic [CFG_DAT_W-1:0] val;
        logic [7:0]           ver;
        logic [WORD_W-1:0]    w;
        int                   sent;
        int                   run_len;
        bit                   clean;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_word  = '0;
        s_first_word = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_KEY_LOW;
        cfg_data     = '0;
        word_known   = 1'b0;
        word_typed   = '0;
        idle_on      = 1'b1;
        for (int i = 0; i < 4; i++) init_keys[i] = '0;
        for (int i = 0; i < KEY_WORDS; i++) key_bank[i] = '0;
        fmt_version = '0;
        cipher_dir  = DIR_DECRYPT;
        mix_index   = '0;
        link_a      = '0;
        link_b      = '0;
        hold_one    = '0;
        hold_two    = '0;
        block_pos   = '0;

        key_regs = '{REG_KEY_LOW, REG_KEY_MID_LOW, REG_KEY_MID_HIGH, REG_KEY_HIGH};
        version_plan = '{VER_FIX_LO, VER_ALT, 8'hFF, 8'h00, VER_FIX_LO + 8'd1, VER_FIX_HI,
                         VER_FIX_LO - 8'd1, VER_FIX_HI + 8'd1, VER_ALT, VER_ALT - 8'd1,
                         VER_ALT + 8'd1, 8'h00};

        // No reload after reset: zero keys, so the first words come back unchanged;
        // a reload from the all-zero registers restarts that.
        directed_rows = '{
            '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF}, '{16'h0000, 1'b0, 1'b1, 16'h0000},
            '{16'h8000, 1'b0, 1'b0, 16'h0000}, '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
            '{16'h5555, 1'b0, 1'b0, 16'h0000}, '{16'hAAAA, 1'b0, 1'b0, 16'h0000},
            '{16'h0001, 1'b0, 1'b0, 16'h0000}, '{16'hFFFE, 1'b0, 1'b0, 16'h0000},
            '{16'h1234, 1'b0, 1'b0, 16'h0000}, '{16'hEDCB, 1'b0, 1'b0, 16'h0000},
            '{16'h00FF, 1'b0, 1'b0, 16'h0000}, '{16'hFF00, 1'b0, 1'b0, 16'h0000},
            '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF}, '{16'h0000, 1'b0, 1'b0, 16'h0000},
            '{16'hFFFF, 1'b0, 1'b0, 16'h0000}, '{16'h8000, 1'b0, 1'b0, 16'h0000},
            '{16'h7FFF, 1'b0, 1'b0, 16'h0000}, '{16'hF0F0, 1'b0, 1'b0, 16'h0000},
            '{16'h0F0F, 1'b0, 1'b0, 16'h0000}, '{16'h3C3C, 1'b0, 1'b0, 16'h0000},
            '{16'hC3C3, 1'b0, 1'b0, 16'h0000}, '{16'h0001, 1'b0, 1'b0, 16'h0000},
            '{16'h8001, 1'b0, 1'b0, 16'h0000}, '{16'hFFFF, 1'b0, 1'b0, 16'h0000}
        };

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            push_word(directed_rows[i].data, directed_rows[i].first,
                      directed_rows[i].known, directed_rows[i].result);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_words();
            // no idling in the closing phases, and none in every fourth one
            idle_on = (ph < N_PHASES - 2) && (ph % 4 != 3);

            write_reg(REG_SPARE_A, {$urandom, $urandom});
            write_reg(REG_SPARE_B, {$urandom, $urandom});
            for (int r = 0; r < 4; r++) begin
                val = (ph == 0) ? '0 : (ph == 1) ? '1 : {$urandom, $urandom};
                write_reg(key_regs[r], val);
            end
            ver = (ph == N_PHASES - 1) ? 8'($urandom_range(0, 255)) : version_plan[ph];
            val = (ph == 0) ? '0 : (ph == 1) ? '1 : {$urandom, $urandom};
            val[7:0] = ver;
            write_reg(REG_VERSION, val);
            val = (ph == 0) ? '0 : (ph == 1) ? '1 : {$urandom, $urandom};
            val[0] = (ph % 2 == 1) ? DIR_ENCRYPT : DIR_DECRYPT;
            write_reg(REG_DIRECTION, val);

            // mostly whole keyed streams across several blocks; some short
            // fragments, some without a reload and a few stray reloads
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8)
                                                      : $urandom_range(20, 70);
                clean = ($urandom_range(0, 9) != 0);
                for (int j = 0; j < run_len && sent < ITEMS_PER_PHASE; j++) begin
                    if ($urandom_range(0, 7) == 0)
                        w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    else
                        w = 16'($urandom);
                    push_word(w, ((j == 0) && clean) || ($urandom_range(0, 63) == 0),
                              1'b0, '0);
                    sent++;
                end
            end
        end

        drain_words();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("[keyed_word_stream_cipher] OK");
        else
            $display("[keyed_word_stream_cipher] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/kwsc_pkg.sv
rtl/kwsc_cfg.sv
rtl/kwsc_front.sv
rtl/kwsc_back.sv
rtl/keyed_word_stream_cipher.sv
rtl/kwsc_checker.sv
sim/tb.sv
